>>> hw/rtl/assert_macros.svh
// Assertion macros used by the back-end RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/cgcs_pkg.sv
// Types, constants and the CRC byte update for the configuration record store.
`timescale 1ns / 1ps
package cgcs_pkg;

   localparam logic ACT_COMMIT = 1'b0;
   localparam logic ACT_VERIFY = 1'b1;

   localparam logic [15:0] CRC_START = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [7:0] ERASED_BYTE = 8'hFF;
   localparam logic [7:0] RECORD_BYTES_RESET = 8'd254;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      SUB_DATA,
      SUB_CRC_LO,
      SUB_CRC_HI
   } sub_type;

   typedef struct packed {
      logic       act;
      logic [7:0] data;
      logic [7:0] pos;
      logic [7:0] len;
      logic       last;
   } op_type;

   typedef struct packed {
      logic       end_of_record;
      logic       crc_ok;
      logic [7:0] read_byte;
      logic       write_issued;
      logic [7:0] position;
   } rsp_type;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/cgcs_front.sv
// Front end: tracks the record position and classifies each accepted item.
`timescale 1ns / 1ps
module cgcs_front #(
   parameter int STORE_BYTES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       record_bytes,
   input  logic             accept,
   input  logic             act,
   input  logic [7:0]       data,
   output cgcs_pkg::op_type op
);

   localparam int CapInt = (STORE_BYTES - 2 < 254) ? STORE_BYTES - 2 : 254;
   localparam logic [7:0] LEN_CAP = 8'(CapInt);

   logic [7:0] byte_position_ff, byte_position_in;
   logic       action_ff, action_in;
   logic [7:0] len;
   logic [7:0] pos;
   logic       last;

   always_comb begin
      if (record_bytes == 8'd0) begin
         len = 8'd1;
      end else if (record_bytes > LEN_CAP) begin
         len = LEN_CAP;
      end else begin
         len = record_bytes;
      end

      pos = byte_position_ff;
      if (pos != 8'd0 && act != action_ff) begin
         pos = 8'd0;
      end
      if (pos >= len) begin
         pos = 8'd0;
      end
      last = ({1'b0, pos} + 9'd1) == {1'b0, len};

      op.act  = act;
      op.data = data;
      op.pos  = pos;
      op.len  = len;
      op.last = last;

      byte_position_in = byte_position_ff;
      action_in = action_ff;
      if (accept) begin
         byte_position_in = last ? 8'd0 : pos + 8'd1;
         action_in = act;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= 8'd0;
         action_ff <= cgcs_pkg::ACT_COMMIT;
      end else begin
         byte_position_ff <= byte_position_in;
         action_ff <= action_in;
      end
   end

endmodule

>>> hw/rtl/cgcs_queue.sv
// Short queue of classified operations between the front and back ends.
`timescale 1ns / 1ps
module cgcs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cgcs_pkg::op_type push_op,
   input  logic             pop,
   output cgcs_pkg::op_type head_op,
   output logic             empty,
   output logic             full
);

   localparam int Depth = cgcs_pkg::QUEUE_DEPTH;
   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   cgcs_pkg::op_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff, count_in;

   assign empty = (count_ff == CntW'(0));
   assign full = (count_ff == CntW'(Depth));
   assign head_op = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

>>> hw/rtl/cgcs_back.sv
// Back end: store memory, read-compare-program, CRC and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cgcs_back #(
   parameter int STORE_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  cgcs_pkg::op_type  head_op,
   input  logic              head_empty,
   output logic              pop,
   output logic              clear_busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cgcs_pkg::rsp_type rsp
);

   localparam int AW = $clog2(STORE_BYTES);

   logic [7:0] mem_ff [STORE_BYTES];

   logic              clearing_ff;
   logic [AW-1:0]     clr_cnt_ff;
   cgcs_pkg::sub_type a_sub_ff, a_sub_in;
   logic              b_valid_ff;
   cgcs_pkg::op_type  b_op_ff;
   cgcs_pkg::sub_type b_sub_ff;
   logic [7:0]        b_addr_ff;
   logic [7:0]        rd_data_ff;
   logic              fwd_hit_ff;
   logic [7:0]        fwd_data_ff;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        lo_ff, lo_in;
   logic              rsp_valid_ff;
   cgcs_pkg::rsp_type rsp_ff;

   logic          out_free, adv, b_fire, issue;
   logic [7:0]    issue_addr;
   logic [7:0]    old_byte, wval, fold_byte;
   logic [15:0]   crc_base, crc_next;
   logic          op_we, crc_match;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign adv = !b_valid_ff || out_free;
   assign b_fire = b_valid_ff && out_free;
   assign issue = adv && !head_empty && !clearing_ff;
   assign clear_busy = clearing_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_comb begin
      a_sub_in = a_sub_ff;
      pop = 1'b0;
      issue_addr = head_op.pos;
      unique case (a_sub_ff)
         cgcs_pkg::SUB_DATA:   issue_addr = head_op.pos;
         cgcs_pkg::SUB_CRC_LO: issue_addr = head_op.len;
         cgcs_pkg::SUB_CRC_HI: issue_addr = head_op.len + 8'd1;
         default:              issue_addr = head_op.pos;
      endcase
      if (issue) begin
         if (head_op.last && a_sub_ff == cgcs_pkg::SUB_DATA) begin
            a_sub_in = cgcs_pkg::SUB_CRC_LO;
         end else if (head_op.last && a_sub_ff == cgcs_pkg::SUB_CRC_LO) begin
            a_sub_in = cgcs_pkg::SUB_CRC_HI;
         end else begin
            a_sub_in = cgcs_pkg::SUB_DATA;
            pop = 1'b1;
         end
      end
   end

   always_comb begin
      old_byte = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      crc_base = (b_op_ff.pos == 8'd0) ? cgcs_pkg::CRC_START : crc_ff;
      fold_byte = (b_op_ff.act == cgcs_pkg::ACT_COMMIT) ? b_op_ff.data : old_byte;
      crc_next = cgcs_pkg::crc_fold(crc_base, fold_byte);
      unique case (b_sub_ff)
         cgcs_pkg::SUB_DATA:   wval = b_op_ff.data;
         cgcs_pkg::SUB_CRC_LO: wval = crc_ff[7:0];
         cgcs_pkg::SUB_CRC_HI: wval = crc_ff[15:8];
         default:              wval = b_op_ff.data;
      endcase
      op_we = b_fire && b_op_ff.act == cgcs_pkg::ACT_COMMIT && old_byte != wval;
      crc_match = {old_byte, lo_ff} == crc_ff;

      crc_in = crc_ff;
      if (b_fire && b_sub_ff == cgcs_pkg::SUB_DATA) begin
         crc_in = crc_next;
      end
      lo_in = lo_ff;
      if (b_fire && b_sub_ff == cgcs_pkg::SUB_CRC_LO) begin
         lo_in = old_byte;
      end

      mem_we = clearing_ff || op_we;
      mem_waddr = clearing_ff ? clr_cnt_ff : AW'(b_addr_ff);
      mem_wdata = clearing_ff ? cgcs_pkg::ERASED_BYTE : wval;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (issue) begin
         rd_data_ff <= mem_ff[AW'(issue_addr)];
         fwd_hit_ff <= op_we && (AW'(b_addr_ff) == AW'(issue_addr));
         fwd_data_ff <= wval;
         b_op_ff <= head_op;
         b_sub_ff <= a_sub_ff;
         b_addr_ff <= issue_addr;
      end
      lo_ff <= lo_in;
      if (b_fire) begin
         rsp_ff.position <= b_addr_ff;
         rsp_ff.write_issued <= op_we;
         rsp_ff.read_byte <= old_byte;
         rsp_ff.crc_ok <= b_op_ff.act == cgcs_pkg::ACT_VERIFY
                          && b_sub_ff == cgcs_pkg::SUB_CRC_HI && crc_match;
         rsp_ff.end_of_record <= b_sub_ff == cgcs_pkg::SUB_CRC_HI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff <= '0;
         a_sub_ff <= cgcs_pkg::SUB_DATA;
         b_valid_ff <= 1'b0;
         crc_ff <= cgcs_pkg::CRC_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(STORE_BYTES - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         a_sub_ff <= a_sub_in;
         if (adv) begin
            b_valid_ff <= issue;
         end
         crc_ff <= crc_in;
         if (b_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `ASSERT_IMP(a_no_op_while_clearing, clock, reset, clearing_ff, !b_valid_ff && !issue)
   `ASSERT_IMP(a_crc_subops_only_last, clock, reset,
               b_valid_ff && b_sub_ff != cgcs_pkg::SUB_DATA, b_op_ff.last)
   `ASSERT_NXT(a_stage_holds_on_stall, clock, reset, b_valid_ff && !out_free,
               b_valid_ff && $stable(b_addr_ff) && $stable(b_sub_ff))
   `ASSERT_IMP(a_crc_ok_at_end, clock, reset, rsp_valid_ff && rsp_ff.crc_ok,
               rsp_ff.end_of_record && !rsp_ff.write_issued)

endmodule

>>> hw/rtl/crc_guarded_config_store_core.sv
// Top level of the CRC-guarded configuration record store.
`timescale 1ns / 1ps
// Usage:
//  req channel: one transfer per record byte. req_tuser selects commit (0) or
//  verify (1); req_tdata carries the byte to commit. Switching the action in
//  the middle of a record restarts the record at position zero.
//  rsp channel: one transfer per store address handled. The transfer for the
//  last data byte is followed by the CRC low and high byte transfers; the
//  high byte transfer carries rsp_tlast and, on a verify, the CRC check flag.
//  csr_we/csr_wdata set the record length in bytes; write only while idle.
//  Path: an accepted item passes through the queue, the read stage and the
//  result register. Throughput: one item per cycle while no stall holds it;
//  the last byte of a record is issued three times, for its data and CRC bytes.
//  Reset: the store is erased to 0xFF by a clearing pass over all STORE_BYTES
//  addresses, during which req_tready stays low; the record length returns to 254.
//  Stall: the result register holds while rsp_tready is low; a four-entry
//  queue keeps taking items until it fills.
module crc_guarded_config_store_core #(
   parameter int STORE_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] position, [8] write_issued,
                                    // [16:9] read_byte, [17] crc_ok, [23:18] zero
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]        record_bytes_ff;
   logic              accept;
   cgcs_pkg::op_type  front_op, head_op;
   logic              q_empty, q_full, pop, clear_busy;
   cgcs_pkg::rsp_type rsp;

   assign req_tready = !q_full && !clear_busy;
   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_bytes_ff <= cgcs_pkg::RECORD_BYTES_RESET;
      end else if (csr_we) begin
         record_bytes_ff <= csr_wdata;
      end
   end

   cgcs_front #(
      .STORE_BYTES(STORE_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .record_bytes(record_bytes_ff),
      .accept      (accept),
      .act         (req_tuser),
      .data        (req_tdata),
      .op          (front_op)
   );

   cgcs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (accept),
      .push_op(front_op),
      .pop    (pop),
      .head_op(head_op),
      .empty  (q_empty),
      .full   (q_full)
   );

   cgcs_back #(
      .STORE_BYTES(STORE_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_op   (head_op),
      .head_empty(q_empty),
      .pop       (pop),
      .clear_busy(clear_busy),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {6'd0, rsp.crc_ok, rsp.read_byte, rsp.write_issued, rsp.position};
   assign rsp_tlast = rsp.end_of_record;

endmodule

>>> verif/tb.sv
// Testbench for the CRC-guarded configuration record store, checking every rsp transfer.
`timescale 1ns / 1ps
module tb;

   typedef struct packed {
      logic       act;
      logic [7:0] data;
   } byte_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] position, [8] write_issued,
                                     // [16:9] read_byte, [17] crc_ok, [23:18] zero
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = 8'h00;

   byte_cmd_type      byte_cmd_q[$];
   cgcs_pkg::rsp_type expected_access_q[$];
   logic [7:0]  shadow_store [0:255];
   logic [7:0]  last_record [0:255];
   logic [15:0] shadow_crc;
   logic [7:0]  shadow_pos;
   logic        shadow_act;
   logic [7:0]  shadow_len;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          issued_cmds = 0;
   int          mismatches = 0;
   bit          hold_req = 1'b0;
   logic        req_fire = 1'b0;

   crc_guarded_config_store_core #(
      .STORE_BYTES(256)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      int          i;
      c = crc;
      for (i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c = c >> 1;
         if (fb) begin
            c = c ^ cgcs_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic push_access(input logic [7:0] pos, input logic wr, input logic [7:0] rd,
                              input logic ok, input logic eor);
      cgcs_pkg::rsp_type r;
      r.position = pos;
      r.write_issued = wr;
      r.read_byte = rd;
      r.crc_ok = ok;
      r.end_of_record = eor;
      expected_access_q.push_back(r);
   endtask

   task automatic program_byte(input logic [7:0] addr, input logic [7:0] val, input logic eor);
      logic [7:0] old;
      old = shadow_store[addr];
      push_access(addr, old != val, old, 1'b0, eor);
      shadow_store[addr] = val;
   endtask

   task automatic apply_record_byte(input logic act, input logic [7:0] data);
      int         eff;
      logic [7:0] pos;
      logic       last;
      logic [7:0] lo;
      logic [7:0] hi;
      eff = shadow_len;
      if (eff < 1) eff = 1;
      if (eff > 254) eff = 254;
      if (shadow_pos != 0 && act != shadow_act) shadow_pos = 0;
      if (shadow_pos >= eff) shadow_pos = 0;
      if (shadow_pos == 0) begin
         shadow_crc = cgcs_pkg::CRC_START;
         shadow_act = act;
      end
      pos = shadow_pos;
      last = (pos + 1 == eff);
      if (act == cgcs_pkg::ACT_COMMIT) begin
         program_byte(pos, data, 1'b0);
         shadow_crc = crc_next(shadow_crc, data);
         if (last) begin
            program_byte(8'(eff), shadow_crc[7:0], 1'b0);
            program_byte(8'(eff + 1), shadow_crc[15:8], 1'b1);
         end
      end else begin
         shadow_crc = crc_next(shadow_crc, shadow_store[pos]);
         push_access(pos, 1'b0, shadow_store[pos], 1'b0, 1'b0);
         if (last) begin
            lo = shadow_store[eff];
            hi = shadow_store[eff + 1];
            push_access(8'(eff), 1'b0, lo, 1'b0, 1'b0);
            push_access(8'(eff + 1), 1'b0, hi, {hi, lo} == shadow_crc, 1'b1);
         end
      end
      shadow_pos = last ? 8'd0 : pos + 8'd1;
   endtask

   task automatic queue_cmd(input logic act, input logic [7:0] data);
      byte_cmd_type c;
      c.act = act;
      c.data = data;
      byte_cmd_q.push_back(c);
      issued_cmds++;
   endtask

   task automatic queue_record(input int len);
      int         kind;
      int         k;
      int         flip_at;
      logic [7:0] d;
      kind = $urandom_range(9);
      if (kind <= 3) begin
         for (k = 0; k < len; k++) begin
            last_record[k] = 8'($urandom_range(255));
            queue_cmd(cgcs_pkg::ACT_COMMIT, last_record[k]);
         end
      end else if (kind <= 5) begin
         flip_at = $urandom_range(len);
         for (k = 0; k < len; k++) begin
            d = last_record[k];
            if (k == flip_at) d = d ^ (8'h01 << $urandom_range(7));
            last_record[k] = d;
            queue_cmd(cgcs_pkg::ACT_COMMIT, d);
         end
      end else if (kind <= 8) begin
         for (k = 0; k < len; k++) begin
            queue_cmd(cgcs_pkg::ACT_VERIFY, 8'($urandom_range(255)));
         end
      end else begin
         for (k = $urandom_range(1, 4); k > 0; k--) begin
            queue_cmd(1'($urandom_range(1)), 8'($urandom_range(255)));
         end
      end
   endtask

   task automatic wait_store_idle();
      do @(posedge clock);
      while (byte_cmd_q.size() != 0 || req_tvalid || expected_access_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_record_len(input logic [7:0] value);
      wait_store_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      shadow_len = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // predict on every accepted item
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         apply_record_byte(req_tuser, req_tdata);
      end
   end

   always @(negedge clock) begin : driver
      byte_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (byte_cmd_q.size() != 0 && !hold_req && $urandom_range(99) >= req_idle_pct) begin
            c = byte_cmd_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= c.act;
            req_tdata <= c.data;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : monitor
      cgcs_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_access_q.size() == 0) begin
            report_mismatch("transfer with nothing pending, position", rsp_tdata[7:0], 0);
         end else begin
            want = expected_access_q.pop_front();
            if (rsp_tdata[7:0] !== want.position)
               report_mismatch("position", rsp_tdata[7:0], want.position);
            if (rsp_tdata[8] !== want.write_issued)
               report_mismatch("write_issued", rsp_tdata[8], want.write_issued);
            if (rsp_tdata[16:9] !== want.read_byte)
               report_mismatch("read_byte", rsp_tdata[16:9], want.read_byte);
            if (rsp_tdata[17] !== want.crc_ok)
               report_mismatch("crc_ok", rsp_tdata[17], want.crc_ok);
            if (rsp_tlast !== want.end_of_record)
               report_mismatch("end_of_record", rsp_tlast, want.end_of_record);
         end
      end
   end

   initial begin : stimulus
      int idle_mode [0:3];
      int stall_mode [0:3];
      int ph;
      int k;
      int first_cmd;
      idle_mode = '{0, 60, 0, 23};
      stall_mode = '{0, 0, 60, 23};
      for (k = 0; k < 256; k++) begin
         shadow_store[k] = cgcs_pkg::ERASED_BYTE;
         last_record[k] = 8'($urandom_range(255));
      end
      shadow_crc = cgcs_pkg::CRC_START;
      shadow_pos = 8'd0;
      shadow_act = cgcs_pkg::ACT_COMMIT;
      shadow_len = cgcs_pkg::RECORD_BYTES_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // hold through the clearing pass
      do @(posedge clock);
      while (!req_tready);

      write_record_len(8'd1);
      queue_cmd(cgcs_pkg::ACT_COMMIT, 8'h00);
      queue_cmd(cgcs_pkg::ACT_COMMIT, 8'hFF);
      queue_cmd(cgcs_pkg::ACT_COMMIT, 8'hFF);
      queue_cmd(cgcs_pkg::ACT_VERIFY, 8'h00);
      write_record_len(8'd0);
      queue_cmd(cgcs_pkg::ACT_VERIFY, 8'hFF);
      queue_cmd(cgcs_pkg::ACT_COMMIT, 8'hA5);
      queue_cmd(cgcs_pkg::ACT_VERIFY, 8'h5A);
      write_record_len(8'd3);
      queue_cmd(cgcs_pkg::ACT_COMMIT, 8'h12);
      queue_cmd(cgcs_pkg::ACT_COMMIT, 8'h34);
      queue_cmd(cgcs_pkg::ACT_VERIFY, 8'h00);
      queue_cmd(cgcs_pkg::ACT_VERIFY, 8'h00);
      queue_cmd(cgcs_pkg::ACT_VERIFY, 8'h00);
      queue_cmd(cgcs_pkg::ACT_COMMIT, 8'h80);
      queue_cmd(cgcs_pkg::ACT_COMMIT, 8'h01);
      queue_cmd(cgcs_pkg::ACT_COMMIT, 8'h7F);
      queue_cmd(cgcs_pkg::ACT_VERIFY, 8'hFF);
      queue_cmd(cgcs_pkg::ACT_VERIFY, 8'hFF);
      queue_cmd(cgcs_pkg::ACT_VERIFY, 8'hFF);
      write_record_len(8'd2);
      queue_cmd(cgcs_pkg::ACT_VERIFY, 8'h00);
      queue_cmd(cgcs_pkg::ACT_VERIFY, 8'h00);

      // partial record with a saturated length
      write_record_len(8'd255);
      for (k = 0; k < 20; k++) queue_cmd(cgcs_pkg::ACT_COMMIT, 8'($urandom_range(255)));
      for (k = 0; k < 20; k++) queue_cmd(cgcs_pkg::ACT_VERIFY, 8'($urandom_range(255)));

      for (ph = 0; ph < 4; ph++) begin
         write_record_len(8'($urandom_range(1, 12)));
         req_idle_pct = idle_mode[ph];
         rsp_stall_pct = stall_mode[ph];
         first_cmd = issued_cmds;
         while (issued_cmds - first_cmd < 40) queue_record(shadow_len);
         if (ph == 1) begin
            while (byte_cmd_q.size() > 25) @(posedge clock);
            hold_req = 1'b1;
            do @(posedge clock);
            while (req_tvalid || expected_access_q.size() != 0);
            hold_req = 1'b0;
         end
      end

      wait_store_idle();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
